// ----- src/paqi_pkg.sv -----
package paqi_pkg;

  localparam int unsigned DefCapacity = 32;
  localparam int unsigned PosW = 24;
  localparam int unsigned AgeW = 16;
  localparam logic [15:0] LifeReset = 16'd39322;

  typedef enum logic [1:0] {
    CmdAdd  = 2'd0,
    CmdTick = 2'd1,
    CmdDraw = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindAdd  = 2'd0,
    KindTick = 2'd1,
    KindRec  = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] vx;
    logic signed [PosW-1:0] vy;
    logic [AgeW-1:0]        age;
  } part_t;

  // pos + floor(dt*vel / 2^16), saturated to 24 bits
  function automatic logic signed [PosW-1:0] sat_add(
      input logic signed [PosW-1:0] pos, input logic signed [PosW+16:0] prod);
    logic signed [PosW+17:0] s;
    s = $signed({{18{pos[PosW-1]}}, pos}) + ($signed({prod[PosW+16], prod}) >>> 16);
    if (s > $signed({18'd0, 24'h7FFFFF})) begin
      return 24'h7FFFFF;
    end else if (s < -$signed({18'd0, 24'h800000})) begin
      return 24'h800000;
    end
    return s[PosW-1:0];
  endfunction

endpackage

// ----- src/paqi_cell.sv -----
module paqi_cell
  import paqi_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  logic  tick_i,
  input  logic [AgeW-1:0] dt_i,
  input  part_t prev_i,
  output part_t data_o
);

  part_t data_q;
  part_t upd;
  logic signed [PosW+16:0] prod_x, prod_y;
  logic [AgeW:0] age_sum;

  // advance the word entering this cell while the tick strobe is up
  always_comb begin
    prod_x = $signed({1'b0, dt_i}) * $signed(prev_i.vx);
    prod_y = $signed({1'b0, dt_i}) * $signed(prev_i.vy);
    age_sum = {1'b0, prev_i.age} + {1'b0, dt_i};
    upd = prev_i;
    if (tick_i) begin
      upd.px = sat_add(prev_i.px, prod_x);
      upd.py = sat_add(prev_i.py, prod_y);
      upd.age = age_sum[AgeW] ? {AgeW{1'b1}} : age_sum[AgeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= upd;
    end
  end

  assign data_o = data_q;

endmodule

// ----- src/paqi_coldiv.sv -----
module paqi_coldiv
  import paqi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AgeW-1:0] age_i,
  input  logic [AgeW-1:0] life_i,
  output logic            done_o,
  output logic [2:0]      col_o
);

  // restoring division of 4*age by life, three quotient bits then saturate
  logic [AgeW+1:0] rem_q, rem_d;
  logic [2:0]      quo_q, quo_d;
  logic [1:0]      step_q, step_d;
  logic            busy_q, busy_d, ovf_q, ovf_d, done_q, done_d;
  logic [AgeW+2:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; step_d = step_q; busy_d = busy_q;
    ovf_d = ovf_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      // a zero lifetime or an age at or past the lifetime saturates the column
      rem_d = {age_i, 2'b00};
      ovf_d = (life_i == '0) || (age_i >= life_i);
      quo_d = '0; step_d = 2'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {1'b0, rem_q} - ({3'b0, life_i} << (2'd2 - step_q));
      if (!trial[AgeW+2]) begin
        rem_d = trial[AgeW+1:0];
        quo_d[2'd2 - step_q] = 1'b1;
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; ovf_q <= ovf_d;
  end

  logic [3:0] colw;
  assign colw = 4'd3 + {1'b0, quo_q};
  assign done_o = done_q;
  assign col_o = (ovf_q || colw > 4'd7) ? 3'd7 : colw[2:0];

endmodule

// ----- src/particle_age_queue_integrator.sv -----
// Particle queue with Euler update, oldest particle first.
// Channels: input words (cmd, positions, velocities, dt) on in_valid_i/in_ready_o;
// result words on out_valid_o/out_ready_i; life_length on cfg_valid_i/cfg_ready_o,
// taken only while the block is idle with no result word waiting.
// Particles sit in a ring of CAPACITY cells that rotates one place per shift;
// the oldest is always at cell 0 between commands.
// Add: the status word follows one full rotation of the ring, the new particle
// entering the tail as its slot passes; a drop on a full queue answers in the
// next cycle. Tick: one full rotation, the tail cell advancing each live word it
// takes in, then the expired particles are dropped from the front before the
// status word. Draw: each record runs the three-step column divider and is then
// handed over; after the last record the ring turns on until it is aligned; an
// empty queue answers in the next cycle. Cost grows with the fill on draw and
// with the number of expired particles on tick.
// One input word is worked at a time; the next is taken once the final result
// word has been handed over and the ring is aligned. A stalled receiver holds
// the block. Reset empties the queue and loads the default lifetime; cell
// contents stay undefined until written.
module particle_age_queue_integrator
  import paqi_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] vel_x_i,
  input  logic signed [23:0] vel_y_i,
  input  logic [15:0] dt_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] kind_o,
  output logic accepted_o,
  output logic [5:0] count_o,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_y_o,
  output logic [2:0] frame_column_o,
  output logic valid_res_o,
  output logic last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    StIdle, StRot, StExpire, StDiv, StOut, StAlign
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic               acc;
    logic [5:0]         cnt;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [2:0]         col;
    logic               vres;
    logic               last;
  } word_t;

  state_e state_q, state_d;
  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] k_q, k_d;
  logic [15:0] life_q, life_d;
  logic [15:0] dt_q;
  cmd_e cmd_q, cmd_d;
  part_t newp_q;
  logic div_go_q, div_go_d;
  logic out_v_q, out_v_d;
  word_t out_q, out_d;

  logic shift, tail_tick, ins, in_fire;
  part_t tail_in;
  part_t cell_q [CAPACITY];

  logic div_done;
  logic [2:0] div_col;

  function automatic word_t status_word(kind_e kind, logic acc, logic [5:0] cnt);
    word_t w;
    w = '0;
    w.kind = kind;
    w.acc = acc;
    w.cnt = cnt;
    w.last = 1'b1;
    return w;
  endfunction

  // ring: cell i takes from cell i+1, the last cell from cell 0
  // (inserting a new particle at the tail position when due)
  assign tail_in = ins ? newp_q : cell_q[0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    part_t prv;
    logic  tk;
    if (g == CAPACITY - 1) begin : g_tail
      assign prv = tail_in;
      assign tk  = tail_tick;
    end else begin : g_mid
      assign prv = cell_q[g+1];
      assign tk  = 1'b0;
    end
    paqi_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .tick_i (tk),
      .dt_i   (dt_q),
      .prev_i (prv),
      .data_o (cell_q[g])
    );
  end

  paqi_coldiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go_q),
    .age_i  (cell_q[0].age),
    .life_i (life_q),
    .done_o (div_done),
    .col_o  (div_col)
  );

  assign in_ready_o  = (state_q == StIdle) && !out_v_q;
  assign cfg_ready_o = (state_q == StIdle) && !out_v_q;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    k_d      = k_q;
    cmd_d    = cmd_q;
    life_d   = life_q;
    div_go_d = 1'b0;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    shift     = 1'b0;
    tail_tick = 1'b0;
    ins       = 1'b0;
    if (cfg_valid_i && cfg_ready_o) life_d = cfg_data_i;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          cmd_d = cmd_e'(cmd_i);
          k_d   = '0;
          case (cmd_e'(cmd_i))
            CmdAdd: begin
              if (held_q == CntW'(CAPACITY)) begin
                out_v_d = 1'b1;
                out_d   = status_word(KindAdd, 1'b0, 6'(held_q));
              end else begin
                state_d = StRot;
              end
            end
            CmdTick: state_d = StRot;
            CmdDraw: begin
              if (held_q == '0) begin
                out_v_d = 1'b1;
                out_d   = status_word(KindRec, 1'b0, 6'(held_q));
              end else begin
                state_d  = StDiv;
                div_go_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      StRot: begin
        // the word entering the tail at rotation step k is the one at head
        // offset k; an add inserts when k reaches the held count
        shift     = 1'b1;
        ins       = (cmd_q == CmdAdd) && (k_q == held_q);
        tail_tick = (cmd_q == CmdTick) && (k_q < held_q);
        k_d       = k_q + 1'b1;
        if (k_q == CntW'(CAPACITY - 1)) begin
          k_d = '0;
          if (cmd_q == CmdAdd) begin
            held_d  = held_q + 1'b1;
            out_v_d = 1'b1;
            out_d   = status_word(KindAdd, 1'b1, 6'(held_q + 1'b1));
            state_d = StIdle;
          end else begin
            state_d = StExpire;
          end
        end
      end
      StExpire: begin
        // drop the front; the survivors stay packed from cell 0
        if (held_q != '0 && cell_q[0].age > life_q) begin
          shift  = 1'b1;
          held_d = held_q - 1'b1;
        end else begin
          out_v_d = 1'b1;
          out_d   = status_word(KindTick, 1'b0, 6'(held_q));
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (div_done) begin
          shift      = 1'b1;
          k_d        = k_q + 1'b1;
          out_v_d    = 1'b1;
          out_d      = '0;
          out_d.kind = KindRec;
          out_d.cnt  = 6'(held_q);
          out_d.x    = cell_q[0].px;
          out_d.y    = cell_q[0].py;
          out_d.col  = div_col;
          out_d.vres = 1'b1;
          out_d.last = (k_q + 1'b1 == held_q);
          state_d    = StOut;
        end
      end
      StOut: begin
        if (!out_v_q || out_ready_i) begin
          if (k_q == CntW'(CAPACITY)) begin
            k_d     = '0;
            state_d = StIdle;
          end else if (k_q < held_q) begin
            state_d  = StDiv;
            div_go_d = 1'b1;
          end else begin
            state_d = StAlign;
          end
        end
      end
      StAlign: begin
        // finish the full turn so the oldest is back at cell 0
        shift = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == CntW'(CAPACITY - 1)) begin
          k_d     = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      held_q   <= '0;
      k_q      <= '0;
      life_q   <= LifeReset;
      cmd_q    <= CmdNone;
      div_go_q <= 1'b0;
      out_v_q  <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      k_q      <= k_d;
      life_q   <= life_d;
      cmd_q    <= cmd_d;
      div_go_q <= div_go_d;
      out_v_q  <= out_v_d;
      out_q    <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      newp_q <= '{px: pos_x_i, py: pos_y_i, vx: vel_x_i, vy: vel_y_i, age: '0};
      dt_q   <= dt_i;
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_q.kind;
  assign accepted_o     = out_q.acc;
  assign count_o        = out_q.cnt;
  assign out_x_o        = out_q.x;
  assign out_y_o        = out_q.y;
  assign frame_column_o = out_q.col;
  assign valid_res_o    = out_q.vres;
  assign last_o         = out_q.last;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import paqi_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned SettleCycles = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [5:0]  count;
    logic [23:0] x;
    logic [23:0] y;
    logic [2:0]  column;
    logic        valid;
    logic        last;
  } res_t;

  typedef struct {
    cmd_e        cmd;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] vx;
    logic [23:0] vy;
    logic [15:0] dt;
    bit          typed;
    res_t        want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CmdNone;
  logic signed [23:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [15:0] dt_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic accepted_o;
  logic [5:0] count_o;
  logic signed [23:0] out_x_o, out_y_o;
  logic [2:0] frame_column_o;
  logic valid_res_o, last_o;

  particle_age_queue_integrator #(.CAPACITY(Cap)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the particle ring
  logic signed [23:0] sh_px[Cap], sh_py[Cap], sh_vx[Cap], sh_vy[Cap];
  logic [15:0] sh_age[Cap];
  int unsigned sh_head, sh_count;
  logic [15:0] sh_life;

  // expected words: appended by the stimulus, walked by the checker
  res_t exp_words[$];
  int exp_rd = 0;
  int unsigned mismatches = 0, words_seen = 0;
  int unsigned items_sent, cfg_writes;
  bit quiet;

  function automatic logic signed [23:0] euler_step(logic signed [23:0] pos,
                                                    logic signed [23:0] vel,
                                                    logic [15:0] dt);
    longint p, s;
    p = longint'(dt) * longint'(vel);
    s = longint'(pos) + (p >>> 16);
    if (s > 64'sd8388607) s = 64'sd8388607;
    if (s < -64'sd8388608) s = -64'sd8388608;
    return s[23:0];
  endfunction

  function automatic logic [2:0] anim_column(logic [15:0] age);
    int unsigned c;
    if (sh_life == 0) return 3'd7;
    c = 3 + (4 * int'(age)) / int'(sh_life);
    return (c > 7) ? 3'd7 : c[2:0];
  endfunction

  function automatic res_t status_word(kind_e k, logic acc);
    res_t r;
    r = '0;
    r.kind = k;
    r.accepted = acc;
    r.count = sh_count[5:0];
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_expected(res_t w);
    exp_words = {exp_words, w};
  endtask

  // work out the result words of one accepted item and update the shadow
  task automatic predict_item(row_t it);
    int unsigned i, k;
    res_t r;
    int unsigned a;
    case (it.cmd)
      CmdAdd: begin
        if (sh_count >= Cap) begin
          add_expected(status_word(KindAdd, 1'b0));
        end else begin
          i = (sh_head + sh_count) % Cap;
          sh_px[i] = it.px; sh_py[i] = it.py;
          sh_vx[i] = it.vx; sh_vy[i] = it.vy;
          sh_age[i] = '0;
          sh_count++;
          add_expected(status_word(KindAdd, 1'b1));
        end
      end
      CmdTick: begin
        for (k = 0; k < sh_count; k++) begin
          i = (sh_head + k) % Cap;
          sh_px[i] = euler_step(sh_px[i], sh_vx[i], it.dt);
          sh_py[i] = euler_step(sh_py[i], sh_vy[i], it.dt);
          a = sh_age[i] + it.dt;
          sh_age[i] = (a > 65535) ? 16'hFFFF : a[15:0];
        end
        // drop expired particles from the front
        while (sh_count > 0 && sh_age[sh_head] > sh_life) begin
          sh_head = (sh_head + 1) % Cap;
          sh_count--;
        end
        add_expected(status_word(KindTick, 1'b0));
      end
      CmdDraw: begin
        if (sh_count == 0) add_expected(status_word(KindRec, 1'b0));
        for (k = 0; k < sh_count; k++) begin
          i = (sh_head + k) % Cap;
          r = '0;
          r.kind = KindRec;
          r.count = sh_count[5:0];
          r.x = sh_px[i];
          r.y = sh_py[i];
          r.column = anim_column(sh_age[i]);
          r.valid = 1'b1;
          r.last = (k + 1 == sh_count);
          add_expected(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(row_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    pos_x_i <= it.px; pos_y_i <= it.py;
    vel_x_i <= it.vx; vel_y_i <= it.vy;
    dt_i <= it.dt;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_item(it);
    if (it.typed) exp_words[exp_words.size() - 1] = it.want;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (exp_rd < exp_words.size()) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_life(logic [15:0] value);
    drain_and_settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sh_life = value;
    cfg_writes++;
  endtask

  function automatic row_t rand_item(int unsigned add_weight);
    row_t it;
    int unsigned pick;
    it.typed = 1'b0;
    it.want = '0;
    pick = $urandom_range(0, 99);
    if (pick < add_weight) it.cmd = CmdAdd;
    else if (pick < add_weight + (100 - add_weight) / 2) it.cmd = CmdTick;
    else if (pick < 96) it.cmd = CmdDraw;
    else it.cmd = CmdNone;
    it.px = 24'($urandom); it.py = 24'($urandom);
    if ($urandom_range(0, 1)) begin
      it.vx = 24'($urandom); it.vy = 24'($urandom);
    end else begin
      it.vx = 24'($signed($urandom_range(0, 8191)) - 4096);
      it.vy = 24'($signed($urandom_range(0, 8191)) - 4096);
    end
    it.dt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    return it;
  endfunction

  function automatic row_t mk(cmd_e c, logic [23:0] px, logic [23:0] py, logic [23:0] vx,
                              logic [23:0] vy, logic [15:0] dt, bit typed, res_t want);
    row_t it;
    it.cmd = c; it.px = px; it.py = py; it.vx = vx; it.vy = vy; it.dt = dt;
    it.typed = typed; it.want = want;
    return it;
  endfunction

  // result channel: random stalls, compare each word with the oldest expectation
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_t got, want;
      got = '{kind_o, accepted_o, count_o, out_x_o, out_y_o, frame_column_o,
              valid_res_o, last_o};
      words_seen++;
      if (exp_rd >= exp_words.size()) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = exp_words[exp_rd];
        exp_rd++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [15:0] lives[$];
    int unsigned p, n;
    res_t w;

    sh_head = 0; sh_count = 0; sh_life = LifeReset;
    items_sent = 0; cfg_writes = 0;
    quiet = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    w = '0; w.kind = KindRec; w.last = 1'b1;
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 1, w)};
    w = '0; w.kind = KindTick; w.last = 1'b1;
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 100, 1, w)};
    w = '0; w.kind = KindAdd; w.accepted = 1'b1; w.count = 6'd1; w.last = 1'b1;
    rows = {rows, mk(CmdAdd, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 1, w)};
    w.count = 6'd2;
    rows = {rows, mk(CmdAdd, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 1, w)};
    rows = {rows, mk(CmdAdd, 0, 0, 24'h000001, 24'hFFFFFF, 0, 0, '0)};
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0)};
    w = '0; w.kind = KindTick; w.last = 1'b1;
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 16'hFFFF, 1, w)};
    w = '0; w.kind = KindRec; w.last = 1'b1;
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 1, w)};
    rows = {rows, mk(CmdAdd, 24'h123456, 24'hEDCBA9, 24'h001000, 24'hFFF000, 0, 0, '0)};
    rows = {rows, mk(CmdAdd, 24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'h000001, 0, 0, '0)};
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 13107, 0, '0)};
    rows = {rows, mk(CmdAdd, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 0, 0, '0)};
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk(CmdNone, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
                     0, '0)};
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 13107, 0, '0)};
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk(CmdTick, 0, 0, 0, 0, 19661, 0, '0)};
    rows = {rows, mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0)};
    foreach (rows[i]) send_item(rows[i]);

    // fill past capacity with the longest lifetime, then shorten it
    write_life(16'hFFFF);
    for (n = 0; n < Cap + 3; n++) send_item(mk(CmdAdd, 24'($urandom), 24'($urandom),
                                               24'($urandom), 24'($urandom), 0, 0, '0));
    send_item(mk(CmdTick, 0, 0, 0, 0, 9000, 0, '0));
    send_item(mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0));

    lives = '{16'd1, 16'd0, 16'($urandom_range(1, 65535)), 16'd20000, LifeReset};
    for (p = 0; p < lives.size(); p++) begin
      write_life(lives[p]);
      send_item(mk(CmdDraw, 0, 0, 0, 0, 0, 0, '0));
      if (p == lives.size() - 1) quiet = 1'b1;
      for (n = 0; n < 12; n++) send_item(rand_item(p == 3 ? 60 : 45));
    end

    drain_and_settle();
    $display("tb: %0d items, %0d result words, %0d lifetime writes, %0d mismatches",
             items_sent, words_seen, cfg_writes, mismatches);
    if (mismatches == 0 && exp_rd == exp_words.size()) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
